// ===== hdl/awve_pkg.sv =====
// Shared types and constants for the adaptive weighted-vote ensemble.
// Used by every module of the block but the checker; depends on nothing else.
package awve_pkg;

    // Largest number of outcomes the accuracy window can hold.
    localparam int MAX_WINDOW = 256;
    localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int WIN_LEN_W  = 9;
    localparam int CMP_W      = (WIN_LEN_W > CNT_W) ? WIN_LEN_W : CNT_W;
    localparam int ACC_W      = CNT_W + 3;

    localparam int Q_W       = 16;
    localparam int PROD_W    = 2 * Q_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_CLASS = 3;
    localparam int LABEL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Class order: buy, hold, sell.
    localparam int CLASS_BUY  = 0;
    localparam int CLASS_HOLD = 1;
    localparam int CLASS_SELL = 2;

    localparam logic OP_SCORE  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_IND_W    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_FIRST_W  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SECOND_W = 2'd3;

    localparam logic [WIN_LEN_W-1:0] WINDOW_LENGTH_RST = 9'd100;
    localparam logic [Q_W-1:0] IND_W_RST    = 16'd21845;
    localparam logic [Q_W-1:0] FIRST_W_RST  = 16'd21845;
    localparam logic [Q_W-1:0] SECOND_W_RST = 16'd21846;

    localparam logic [Q_W-1:0] Q_P80  = 16'd52429;
    localparam logic [Q_W-1:0] Q_P10  = 16'd6554;
    localparam logic [Q_W-1:0] Q_U333 = 16'd21823;
    localparam logic [Q_W-1:0] Q_U334 = 16'd21889;
    localparam logic [Q_W-1:0] Q_WMAX = 16'd36045;
    localparam logic [Q_W-1:0] Q_WMIN = 16'd13107;
    localparam logic [Q_W-1:0] Q_STEP = 16'd655;
    localparam int MIN_FILL = 10;

    typedef struct packed {
        logic [Q_W-1:0] indicator;
        logic [Q_W-1:0] first_model;
        logic [Q_W-1:0] second_model;
    } weights_t;

    typedef struct packed {
        logic [1:0]                      indicator_signal;
        logic                            first_ready;
        logic [NUM_CLASS-1:0][Q_W-1:0]   first_prob;
        logic                            second_ready;
        logic [NUM_CLASS-1:0][Q_W-1:0]   second_prob;
        logic [LABEL_W-1:0]              predicted_label;
        logic [LABEL_W-1:0]              actual_label;
    } item_t;

    typedef logic [NUM_CLASS-1:0][SUM_W-1:0] class_sums_t;

endpackage

// ===== hdl/awve_score.sv =====
// Weighted class sums for a score request: nine 16x16 products, six adds.
// Depends on awve_pkg.
module awve_score (
    input  awve_pkg::item_t       item,
    input  awve_pkg::weights_t    weights,
    output awve_pkg::class_sums_t sums
);
    import awve_pkg::*;

    logic [NUM_CLASS-1:0][Q_W-1:0] p_ind;
    logic [NUM_CLASS-1:0][Q_W-1:0] p_first;
    logic [NUM_CLASS-1:0][Q_W-1:0] p_second;

    // Only the sign of the indicator matters: the code for -2 counts as sell.
    always_comb
    begin
        p_ind = {NUM_CLASS{Q_P10}};
        if (item.indicator_signal == 2'b01)
        begin
            p_ind[CLASS_BUY] = Q_P80;
        end
        else if (item.indicator_signal[1])
        begin
            p_ind[CLASS_SELL] = Q_P80;
        end
        else
        begin
            p_ind[CLASS_HOLD] = Q_P80;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CLASS; k++)
        begin
            p_first[k]  = item.first_ready ? item.first_prob[k] :
                          ((k == CLASS_HOLD) ? Q_U334 : Q_U333);
            p_second[k] = item.second_ready ? item.second_prob[k] :
                          ((k == CLASS_HOLD) ? Q_U334 : Q_U333);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CLASS; k++)
        begin
            sums[k] = SUM_W'(PROD_W'(weights.indicator) * PROD_W'(p_ind[k]))
                    + SUM_W'(PROD_W'(weights.first_model) * PROD_W'(p_first[k]))
                    + SUM_W'(PROD_W'(weights.second_model) * PROD_W'(p_second[k]));
        end
    end

endmodule

// ===== hdl/awve_pick.sv =====
// Picks the largest class sum (ties to the lower class) and rounds it to
// a saturated Q0.16 confidence. Depends on awve_pkg.
module awve_pick (
    input  awve_pkg::class_sums_t    sums,
    output logic [awve_pkg::Q_W-1:0] confidence
);
    import awve_pkg::*;

    logic [SUM_W-1:0]   best;
    logic [SUM_W:0]     rounded;
    logic [SUM_W-Q_W:0] scaled;

    always_comb
    begin
        best = sums[CLASS_BUY];
        if (sums[CLASS_HOLD] > best)
        begin
            best = sums[CLASS_HOLD];
        end
        if (sums[CLASS_SELL] > best)
        begin
            best = sums[CLASS_SELL];
        end
    end

    assign rounded = {1'b0, best} + (SUM_W + 1)'(32768);
    assign scaled  = rounded[SUM_W:Q_W];

    assign confidence = (|scaled[SUM_W-Q_W:Q_W]) ? {Q_W{1'b1}} : scaled[Q_W-1:0];

endmodule

// ===== hdl/awve_window.sv =====
// Outcome window and weight adaptation: match ring memory, fill and correct
// counters, live weights and configuration registers. Depends on awve_pkg.
module awve_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [awve_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [awve_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          rec_en,
    input  logic                          hit,
    output awve_pkg::weights_t            weights
);
    import awve_pkg::*;

    logic                 ring_mem [MAX_WINDOW];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     old_ptr_reg, old_ptr_next;
    logic                 old_bit_reg;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     correct_reg, correct_next;
    logic [WIN_LEN_W-1:0] win_len_reg;
    weights_t             weights_reg, weights_next;

    logic [CNT_W-1:0] len_eff;
    logic             drop;
    logic [ACC_W-1:0] five_c, three_f, two_f;
    logic             raise, lower;
    logic [Q_W:0]     w_up_sum;
    logic [Q_W-1:0]   w_new;
    logic [Q_W:0]     rest;

    always_comb
    begin
        if (win_len_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (CMP_W'(win_len_reg) > CMP_W'(MAX_WINDOW))
        begin
            len_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = CNT_W'(win_len_reg);
        end
    end

    // A full window drops its oldest bit before the new one goes in.
    assign drop = (fill_reg >= len_eff);

    always_comb
    begin
        fill_next    = fill_reg;
        correct_next = correct_reg;
        wr_ptr_next  = wr_ptr_reg;
        old_ptr_next = old_ptr_reg;
        if (rec_en)
        begin
            fill_next    = fill_reg - CNT_W'(drop) + CNT_W'(1);
            correct_next = correct_reg - CNT_W'(drop & old_bit_reg) + CNT_W'(hit);
            wr_ptr_next  = (wr_ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0
                         : wr_ptr_reg + PTR_W'(1);
            if (drop)
            begin
                old_ptr_next = (old_ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0
                             : old_ptr_reg + PTR_W'(1);
            end
        end
    end

    assign five_c  = ACC_W'(correct_next) * ACC_W'(5);
    assign three_f = ACC_W'(fill_next) * ACC_W'(3);
    assign two_f   = ACC_W'({fill_next, 1'b0});
    assign raise   = (fill_next >= CNT_W'(MIN_FILL)) && (five_c > three_f);
    assign lower   = (fill_next >= CNT_W'(MIN_FILL)) && !(five_c > three_f)
                     && (five_c < two_f);

    assign w_up_sum = {1'b0, weights_reg.indicator} + {1'b0, Q_STEP};

    always_comb
    begin
        if (raise)
        begin
            w_new = (w_up_sum > {1'b0, Q_WMAX}) ? Q_WMAX : w_up_sum[Q_W-1:0];
        end
        else if ({1'b0, weights_reg.indicator} < ({1'b0, Q_WMIN} + {1'b0, Q_STEP}))
        begin
            w_new = Q_WMIN;
        end
        else
        begin
            w_new = weights_reg.indicator - Q_STEP;
        end
    end

    assign rest = {1'b1, {Q_W{1'b0}}} - {1'b0, w_new};

    always_comb
    begin
        weights_next = weights_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INIT_IND_W:    weights_next.indicator    = cfg_data[Q_W-1:0];
                REG_INIT_FIRST_W:  weights_next.first_model  = cfg_data[Q_W-1:0];
                REG_INIT_SECOND_W: weights_next.second_model = cfg_data[Q_W-1:0];
                default:           weights_next = weights_reg;
            endcase
        end
        else if (rec_en && (raise || lower))
        begin
            weights_next.indicator    = w_new;
            weights_next.first_model  = rest[Q_W:1];
            weights_next.second_model = rest[Q_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            old_ptr_reg  <= '0;
            fill_reg     <= '0;
            correct_reg  <= '0;
            win_len_reg  <= WINDOW_LENGTH_RST;
            weights_reg  <= '{indicator: IND_W_RST, first_model: FIRST_W_RST,
                              second_model: SECOND_W_RST};
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            old_ptr_reg <= old_ptr_next;
            fill_reg    <= fill_next;
            correct_reg <= correct_next;
            weights_reg <= weights_next;
            if (cfg_we && (cfg_index == REG_WINDOW_LENGTH))
            begin
                win_len_reg <= cfg_data[WIN_LEN_W-1:0];
            end
        end
    end

    // The oldest bit is read ahead so it is ready for the next record. A bit
    // written to the address being read is passed straight through.
    always_ff @(posedge clk)
    begin
        if (rec_en)
        begin
            ring_mem[wr_ptr_reg] <= hit;
        end
        if (rec_en && (wr_ptr_reg == old_ptr_next))
        begin
            old_bit_reg <= hit;
        end
        else
        begin
            old_bit_reg <= ring_mem[old_ptr_next];
        end
    end

    assign weights = weights_reg;

endmodule

// ===== hdl/adaptive_weighted_vote_ensemble.sv =====
// A score transfer passes the input register, the class-sum register and the output
// register before its confidence shows on m_tdata; records give no result.
// Throughput: one item per cycle unless a score meets a stalled output, as the class sums
// and the window update finish in the first stage.
// Reset clears the pipeline, ring pointers and counters and loads the default
// weights and window length; the ring memory is not cleared and needs no pass.
module adaptive_weighted_vote_ensemble (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] indicator_signal, [2] first_ready, [18:3] first_prob_buy,
    // [34:19] first_prob_hold, [50:35] first_prob_sell, [51] second_ready,
    // [67:52] second_prob_buy, [83:68] second_prob_hold, [99:84] second_prob_sell,
    // [107:100] predicted_label, [115:108] actual_label, [119:116] zero
    input  logic [119:0] s_tdata,
    // [0] opcode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] confidence
    output logic [15:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import awve_pkg::*;

    logic           s1_valid_reg;
    logic           s1_op_reg;
    item_t          s1_item_reg;
    logic           s2_valid_reg;
    class_sums_t    s2_sums_reg;
    logic           out_valid_reg;
    logic [Q_W-1:0] out_data_reg;

    item_t          in_item;
    weights_t       weights;
    class_sums_t    sums;
    logic [Q_W-1:0] confidence;
    logic           out_load, s2_move, s2_free, s1_fire, accept, rec_en;

    always_comb
    begin
        in_item.indicator_signal         = s_tdata[1:0];
        in_item.first_ready              = s_tdata[2];
        in_item.first_prob[CLASS_BUY]    = s_tdata[18:3];
        in_item.first_prob[CLASS_HOLD]   = s_tdata[34:19];
        in_item.first_prob[CLASS_SELL]   = s_tdata[50:35];
        in_item.second_ready             = s_tdata[51];
        in_item.second_prob[CLASS_BUY]   = s_tdata[67:52];
        in_item.second_prob[CLASS_HOLD]  = s_tdata[83:68];
        in_item.second_prob[CLASS_SELL]  = s_tdata[99:84];
        in_item.predicted_label          = s_tdata[107:100];
        in_item.actual_label             = s_tdata[115:108];
    end

    assign out_load = !out_valid_reg || m_tready;
    assign s2_move  = s2_valid_reg && out_load;
    assign s2_free  = !s2_valid_reg || out_load;
    // A record finishes in the first stage, so it never waits on the output.
    assign s1_fire  = s1_valid_reg && ((s1_op_reg == OP_RECORD) || s2_free);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;
    assign rec_en   = s1_fire && (s1_op_reg == OP_RECORD);

    awve_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_en    (rec_en),
        .hit       (s1_item_reg.predicted_label == s1_item_reg.actual_label),
        .weights   (weights)
    );

    awve_score u_score (
        .item    (s1_item_reg),
        .weights (weights),
        .sums    (sums)
    );

    awve_pick u_pick (
        .sums       (s2_sums_reg),
        .confidence (confidence)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && (s1_op_reg == OP_SCORE))
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= s_tuser;
            s1_item_reg <= in_item;
        end
        if (s1_fire && (s1_op_reg == OP_SCORE))
        begin
            s2_sums_reg <= sums;
        end
        if (s2_move)
        begin
            out_data_reg <= confidence;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/awve_checker.sv =====
// Port-level checks for the ensemble top level, attached by the bind below.
// Depends only on the top level's ports.
module awve_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Its confidence holds until the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset seen at an edge leaves the output empty by the next edge.
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // With the output register empty nothing downstream can hold the input back.
    assert property (@(posedge clk) !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind adaptive_weighted_vote_ensemble awve_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_adaptive_weighted_vote_ensemble.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the adaptive weighted-vote ensemble: directed table, then random
// phases; confidences match a predictor or a table value. Depends on awve_pkg and the top level.
module tb_adaptive_weighted_vote_ensemble;
    import awve_pkg::*;

    typedef struct {
        logic           is_cfg;
        logic [1:0]     reg_idx;
        logic [15:0]    reg_val;
        logic           op;
        item_t          it;
        logic           typed;
        logic [Q_W-1:0] conf;
    } step_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    // Predictor state, mirroring the block after reset.
    logic [WIN_LEN_W-1:0] win_len = WINDOW_LENGTH_RST;
    logic [Q_W-1:0]       ind_w = IND_W_RST;
    logic [Q_W-1:0]       first_w = FIRST_W_RST;
    logic [Q_W-1:0]       second_w = SECOND_W_RST;
    logic                 hit_ring [MAX_WINDOW];
    logic [PTR_W-1:0]     wptr = '0;
    logic [CNT_W-1:0]     fill = '0;
    logic [CNT_W-1:0]     correct = '0;

    // Expected confidences kept in a ring: written at due_wr, read at due_rd.
    logic [Q_W-1:0] conf_due [64];
    int             due_wr = 0;
    int             due_rd = 0;
    logic [Q_W-1:0] due_conf;
    step_t          plan [64];
    int             plan_len = 0;
    int             mismatches = 0;
    bit             calm = 1'b0;

    adaptive_weighted_vote_ensemble uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [119:0] pack_item(item_t it);
        return {4'b0, it.actual_label, it.predicted_label,
                it.second_prob[CLASS_SELL], it.second_prob[CLASS_HOLD],
                it.second_prob[CLASS_BUY], it.second_ready,
                it.first_prob[CLASS_SELL], it.first_prob[CLASS_HOLD],
                it.first_prob[CLASS_BUY], it.first_ready, it.indicator_signal};
    endfunction

    function automatic logic [Q_W-1:0] predict_confidence(item_t it);
        logic [Q_W-1:0]   vote [NUM_CLASS];
        logic [Q_W-1:0]   pa;
        logic [Q_W-1:0]   pb;
        logic [SUM_W-1:0] sums [NUM_CLASS];
        logic [SUM_W-1:0] top;
        int               best;
        // Only the sign of the indicator matters, so both negative codes vote sell.
        if (it.indicator_signal == 2'b01)
        begin
            vote[CLASS_BUY] = Q_P80; vote[CLASS_HOLD] = Q_P10; vote[CLASS_SELL] = Q_P10;
        end
        else if (it.indicator_signal[1])
        begin
            vote[CLASS_BUY] = Q_P10; vote[CLASS_HOLD] = Q_P10; vote[CLASS_SELL] = Q_P80;
        end
        else
        begin
            vote[CLASS_BUY] = Q_P10; vote[CLASS_HOLD] = Q_P80; vote[CLASS_SELL] = Q_P10;
        end
        for (int k = 0; k < NUM_CLASS; k++)
        begin
            pa = it.first_ready ? it.first_prob[k] : (k == CLASS_HOLD ? Q_U334 : Q_U333);
            pb = it.second_ready ? it.second_prob[k] : (k == CLASS_HOLD ? Q_U334 : Q_U333);
            sums[k] = SUM_W'(ind_w) * SUM_W'(vote[k]) + SUM_W'(first_w) * SUM_W'(pa)
                    + SUM_W'(second_w) * SUM_W'(pb);
        end
        best = CLASS_BUY;
        for (int k = 1; k < NUM_CLASS; k++)
            if (sums[k] > sums[best])
                best = k;
        top = (sums[best] + SUM_W'(32768)) >> Q_W;
        return (top > SUM_W'(16'hFFFF)) ? 16'hFFFF : top[Q_W-1:0];
    endfunction

    function automatic void record_outcome(logic hit);
        logic [CNT_W-1:0] span;
        logic [PTR_W-1:0] oldest;
        int unsigned      w;
        span = (win_len == 0) ? CNT_W'(1) :
               (win_len > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(win_len);
        // A full window slides: the oldest outcome leaves before the new one enters.
        if (fill >= span && fill > 0)
        begin
            oldest = PTR_W'(wptr - fill);
            if (hit_ring[oldest])
                correct--;
            fill--;
        end
        hit_ring[wptr] = hit;
        wptr++;
        fill++;
        if (hit)
            correct++;
        if (fill < MIN_FILL)
            return;
        w = 32'(ind_w);
        if (5 * correct > 3 * fill)
        begin
            w = w + Q_STEP;
            if (w > Q_WMAX)
                w = 32'(Q_WMAX);
        end
        else if (5 * correct < 2 * fill)
            w = (w < Q_WMIN + Q_STEP) ? 32'(Q_WMIN) : w - Q_STEP;
        else
            return;
        ind_w = w[Q_W-1:0];
        first_w = Q_W'((32'h10000 - w) >> 1);
        second_w = Q_W'((32'h10000 - w) >> 1);
    endfunction

    function automatic logic [Q_W-1:0] pick_prob();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return Q_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [Q_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return IND_W_RST;
            default: return Q_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic item_t mk_score(logic [1:0] sig, logic fr, logic [15:0] fb,
                                       logic [15:0] fh, logic [15:0] fs, logic sr,
                                       logic [15:0] sb, logic [15:0] sh, logic [15:0] ss);
        item_t it;
        it = '0;
        it.indicator_signal = sig;
        it.first_ready = fr;
        it.first_prob[CLASS_BUY] = fb;
        it.first_prob[CLASS_HOLD] = fh;
        it.first_prob[CLASS_SELL] = fs;
        it.second_ready = sr;
        it.second_prob[CLASS_BUY] = sb;
        it.second_prob[CLASS_HOLD] = sh;
        it.second_prob[CLASS_SELL] = ss;
        return it;
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [15:0] val);
        plan[plan_len] = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, op: OP_SCORE, it: '0,
                           typed: 1'b0, conf: '0};
        plan_len++;
    endfunction

    function automatic void add_score(item_t it, logic typed, logic [Q_W-1:0] conf);
        plan[plan_len] = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, op: OP_SCORE, it: it,
                           typed: typed, conf: conf};
        plan_len++;
    endfunction

    function automatic void add_record(logic [7:0] pred, logic [7:0] act);
        item_t it;
        it = '0;
        it.predicted_label = pred;
        it.actual_label = act;
        plan[plan_len] = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, op: OP_RECORD, it: it,
                           typed: 1'b0, conf: '0};
        plan_len++;
    endfunction

    task automatic make_random(input int hit_pct, output logic op, output item_t it);
        it = mk_score(2'($urandom_range(0, 3)), $urandom_range(0, 3) != 0, pick_prob(),
                      pick_prob(), pick_prob(), $urandom_range(0, 3) != 0, pick_prob(),
                      pick_prob(), pick_prob());
        op = $urandom_range(0, 1) ? OP_RECORD : OP_SCORE;
        it.predicted_label = 8'($urandom_range(0, 255));
        // Mostly outcomes drawn at the phase's hit rate; one in eight is plain noise.
        if ($urandom_range(0, 7) == 0)
            it.actual_label = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 99) < hit_pct)
            it.actual_label = it.predicted_label;
        else
            it.actual_label = it.predicted_label ^ 8'($urandom_range(1, 255));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_WINDOW_LENGTH: win_len = val[WIN_LEN_W-1:0];
            REG_INIT_IND_W:    ind_w = val;
            REG_INIT_FIRST_W:  first_w = val;
            REG_INIT_SECOND_W: second_w = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic op, input item_t it, input logic typed,
                             input logic [Q_W-1:0] conf);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pack_item(it);
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        if (op == OP_SCORE)
        begin
            conf_due[due_wr % $size(conf_due)] = typed ? conf : predict_confidence(it);
            due_wr++;
        end
        else
            record_outcome(it.predicted_label == it.actual_label);
    endtask

    // Records give no result, so the drain waits past the last result to let the window update settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_rd != due_wr)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_rd == due_wr)
            begin
                mismatches++;
                if (mismatches < 200)
                    $display("%0t: confidence expected none, got %0d", $time, m_tdata);
            end
            else
            begin
                due_conf = conf_due[due_rd % $size(conf_due)];
                due_rd++;
                if (m_tdata !== due_conf)
                begin
                    mismatches++;
                    if (mismatches < 200)
                        $display("%0t: confidence expected %0d, got %0d",
                                 $time, due_conf, m_tdata);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("adaptive_weighted_vote_ensemble: mismatch");
        $finish;
    end

    initial
    begin
        logic        op;
        item_t       it;
        int          hit_pct;
        logic [15:0] wl;
        logic        prev_cfg;
        int unsigned phase_win [12];
        phase_win = '{256, 20, 511, 0, 10, 300, 9, 1, 64, 150, 12, 100};

        add_score(mk_score(2'b00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0),
                  1'b0, '0);
        add_score(mk_score(2'b01, 1'b1, 16'd40000, 16'd15000, 16'd10536, 1'b1, 16'd1000,
                           16'd2000, 16'd62536), 1'b0, '0);
        add_score(mk_score(2'b11, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0,
                           16'hFFFF, 16'd0), 1'b0, '0);
        add_score(mk_score(2'b10, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF,
                           16'hFFFF, 16'hFFFF), 1'b0, '0);
        // All weights zero: every class sum is zero.
        add_cfg(REG_INIT_IND_W, 16'd0);
        add_cfg(REG_INIT_FIRST_W, 16'd0);
        add_cfg(REG_INIT_SECOND_W, 16'd0);
        add_score(mk_score(2'b01, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,
                           16'hFFFF, 16'hFFFF), 1'b1, 16'd0);
        // All weights full scale: the confidence saturates.
        add_cfg(REG_INIT_IND_W, 16'hFFFF);
        add_cfg(REG_INIT_FIRST_W, 16'hFFFF);
        add_cfg(REG_INIT_SECOND_W, 16'hFFFF);
        add_score(mk_score(2'b01, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,
                           16'hFFFF, 16'hFFFF), 1'b1, 16'hFFFF);
        // Only the first model counts, and all three classes tie.
        add_cfg(REG_INIT_IND_W, 16'd0);
        add_cfg(REG_INIT_SECOND_W, 16'd0);
        add_score(mk_score(2'b00, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,
                           16'hFFFF, 16'hFFFF), 1'b1, 16'd65534);
        add_score(mk_score(2'b00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0),
                  1'b0, '0);
        // A zero window length behaves as a window of one.
        add_cfg(REG_WINDOW_LENGTH, 16'd0);
        add_cfg(REG_INIT_IND_W, IND_W_RST);
        add_cfg(REG_INIT_FIRST_W, FIRST_W_RST);
        add_cfg(REG_INIT_SECOND_W, SECOND_W_RST);
        add_record(8'd255, 8'd255);
        add_record(8'd0, 8'd255);
        add_score(mk_score(2'b01, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd300, 16'd500,
                           16'd700), 1'b0, '0);
        // A run of hits pushes the accuracy high enough to raise the indicator weight.
        add_cfg(REG_WINDOW_LENGTH, 16'd12);
        for (int i = 0; i < 11; i++)
            add_record(8'(i * 23), 8'(i * 23));
        add_score(mk_score(2'b01, 1'b1, 16'd30000, 16'd20000, 16'd15536, 1'b1, 16'd5000,
                           16'd50000, 16'd10536), 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        prev_cfg = 1'b0;
        for (int i = 0; i < plan_len; i++)
        begin
            if (plan[i].is_cfg)
            begin
                if (!prev_cfg)
                    drain_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                idle_gap();
                send_item(plan[i].op, plan[i].it, plan[i].typed, plan[i].conf);
            end
            prev_cfg = plan[i].is_cfg;
        end

        for (int p = 0; p < 12; p++)
        begin
            drain_results();
            if (p == 11)
                calm = 1'b1;
            wl = 16'(phase_win[p]);
            if ($urandom_range(0, 3) == 0)
                wl[15:WIN_LEN_W] = 7'($urandom_range(0, 127));
            write_reg(REG_WINDOW_LENGTH, wl);
            if ($urandom_range(0, 1))
                write_reg(REG_INIT_IND_W, pick_weight());
            if ($urandom_range(0, 1))
                write_reg(REG_INIT_FIRST_W, pick_weight());
            if ($urandom_range(0, 1))
                write_reg(REG_INIT_SECOND_W, pick_weight());
            hit_pct = (p % 3 == 0) ? 88 : (p % 3 == 1) ? 12 : $urandom_range(30, 70);
            for (int n = 0; n < 136; n++)
            begin
                make_random(hit_pct, op, it);
                idle_gap();
                send_item(op, it, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("adaptive_weighted_vote_ensemble: match");
        else
            $display("adaptive_weighted_vote_ensemble: mismatch");
        $finish;
    end

endmodule
